// File: hw/rtl/msts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msts_pkg
// Shared types and constants of the Markov chain transition sampler.
// ----------------------------------------------------------------------------
package msts_pkg;

    localparam int DEF_TIME_SLOTS = 1024;
    localparam int DEF_NUM_STATES = 13;

    localparam int CMD_W         = 2;
    localparam int RND_W         = 16;
    localparam int ESTATE_W      = 4;
    localparam int ESLOT_W       = 2;
    localparam int THR_W         = 16;
    localparam int ENEXT_W       = 4;
    localparam int TSLOT_W       = 10;
    localparam int OSTATE_W      = 4;
    localparam int OSLOT_W       = 10;
    localparam int TALLY_W       = 16;
    localparam int INTERVAL_W    = 10;
    localparam int COUNTER_W     = 20;
    localparam int SLOTS_PER_ROW = 3;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd100;
    localparam logic [COUNTER_W-1:0]  COUNTER_MAX    = '1;
    localparam logic [TALLY_W-1:0]    TALLY_MAX      = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                command;
        logic [RND_W-1:0]    random_value;
        logic [ESTATE_W-1:0] entry_state;
        logic [ESLOT_W-1:0]  entry_slot;
        logic [THR_W-1:0]    entry_threshold;
        logic [ENEXT_W-1:0]  entry_next;
        logic [TSLOT_W-1:0]  tally_slot;
    } in_item_t;

    typedef struct packed {
        logic [OSTATE_W-1:0] chain_state_out;
        logic                sampled;
        logic [OSLOT_W-1:0]  slot_out;
        logic [TALLY_W-1:0]  tally_count;
    } out_item_t;

    // step_counter split into remainder and quotient by the interval
    typedef struct packed {
        logic [INTERVAL_W-1:0] phase;
        logic [COUNTER_W-1:0]  slot;
    } div_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/msts_interval_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msts_interval_div
// Restoring divider, one quotient bit per cycle: splits the step count into
// slot (quotient) and phase (remainder) after an interval change.
// ----------------------------------------------------------------------------
module msts_interval_div
    import msts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [COUNTER_W-1:0]  dividend,
    input  wire logic [INTERVAL_W-1:0] divisor,
    output div_status_t                status,
    output div_result_t                result
);

    localparam int ITER_W = $clog2(COUNTER_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(COUNTER_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ITER_W-1:0]     cnt_reg;
    logic [INTERVAL_W-1:0] rem_reg;
    logic [COUNTER_W-1:0]  quo_reg;
    logic [INTERVAL_W-1:0] dvs_reg;

    logic [INTERVAL_W:0]   shifted;
    logic [INTERVAL_W:0]   diff;
    logic                  ge;
    logic [INTERVAL_W-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[COUNTER_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? diff[INTERVAL_W-1:0] : shifted[INTERVAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ITER_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[COUNTER_W-2:0], ge};
        end
    end

    assign status.busy   = busy_reg;
    assign status.done   = done_reg;
    assign result.phase  = rem_reg;
    assign result.slot   = quo_reg;

endmodule
`default_nettype wire

// File: hw/rtl/msts_thr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msts_thr_mem
// Threshold table: one row per chain state, three threshold/target entries
// per row, per-entry write enable, registered row read.
// ----------------------------------------------------------------------------
module msts_thr_mem
    import msts_pkg::*;
#(
    parameter  int NUM_STATES = DEF_NUM_STATES,
    localparam int STATE_W    = $clog2(NUM_STATES),
    localparam int ENTRY_W    = THR_W + STATE_W
)
(
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [STATE_W-1:0]                    waddr,
    input  wire logic [ESLOT_W-1:0]                    wslot,
    input  wire logic [ENTRY_W-1:0]                    wdata,
    input  wire logic                                  re,
    input  wire logic [STATE_W-1:0]                    raddr,
    output logic [SLOTS_PER_ROW-1:0][ENTRY_W-1:0]      rdata
);

    logic [SLOTS_PER_ROW-1:0][ENTRY_W-1:0] mem [NUM_STATES];
    logic [SLOTS_PER_ROW-1:0][ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wslot] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/msts_tally_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msts_tally_mem
// Occupancy tally memory, addressed {state, time slot}, one write and one
// registered read port; zeroes every word once after reset.
// ----------------------------------------------------------------------------
module msts_tally_mem
    import msts_pkg::*;
#(
    parameter  int NUM_STATES = DEF_NUM_STATES,
    parameter  int TIME_SLOTS = DEF_TIME_SLOTS,
    localparam int STATE_W    = $clog2(NUM_STATES),
    localparam int SLOT_W     = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1,
    localparam int ADDR_W     = STATE_W + SLOT_W
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               re,
    input  wire logic [ADDR_W-1:0]  raddr,
    output logic [TALLY_W-1:0]      rdata,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [TALLY_W-1:0] wdata,
    output logic                    clear_busy
);

    localparam int DEPTH = NUM_STATES << SLOT_W;
    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(DEPTH - 1);

    logic [TALLY_W-1:0] mem [DEPTH];
    logic [TALLY_W-1:0] rdata_reg;
    logic               clear_busy_reg;
    logic [ADDR_W-1:0]  clear_cnt_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [TALLY_W-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == CLEAR_LAST)
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        mem_we    = clear_busy_reg | we;
        mem_waddr = clear_busy_reg ? clear_cnt_reg : waddr;
        mem_wdata = clear_busy_reg ? '0 : wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clear_busy_reg;

endmodule
`default_nettype wire

// File: hw/rtl/markov_chain_transition_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// markov_chain_transition_sampler_unit
// A request passes the stage 1, stage 2 and output registers in turn.
// A new request is taken once stage 1 has emptied, as the threshold row read
//   precedes the current-state update; the tally write overlaps the next.
// Interval write: the divider recomputes remainder and quotient, then they
//   are loaded into phase and slot; requests are held off meanwhile.
// Reset: a clear pass zeroes all NUM_STATES << SLOT_W tally words (13312 by
//   default); requests are held off, interval writes are still taken.
// ----------------------------------------------------------------------------
module markov_chain_transition_sampler_unit
    import msts_pkg::*;
#(
    parameter int TIME_SLOTS = DEF_TIME_SLOTS,
    parameter int NUM_STATES = DEF_NUM_STATES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [INTERVAL_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data
);

    localparam int STATE_W = $clog2(NUM_STATES);
    localparam int SLOT_W  = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
    localparam int ADDR_W  = STATE_W + SLOT_W;
    localparam int ENTRY_W = THR_W + STATE_W;
    localparam logic [COUNTER_W-1:0] SLOT_LIMIT  = COUNTER_W'(TIME_SLOTS);
    localparam logic [ESTATE_W:0]    STATE_LIMIT = (ESTATE_W + 1)'(NUM_STATES);

    // architectural state
    logic [INTERVAL_W-1:0] interval_reg;
    logic [STATE_W-1:0]    current_state_reg;
    logic [COUNTER_W-1:0]  step_counter_reg;
    logic [INTERVAL_W-1:0] phase_reg;
    logic [COUNTER_W-1:0]  slot_reg;

    // pipeline
    logic                  s1_valid_reg;
    in_item_t              s1_item_reg;
    logic                  s2_valid_reg;
    cmd_t                  s2_cmd_reg;
    logic [STATE_W-1:0]    s2_state_reg;
    logic                  s2_sampled_reg;
    logic [OSLOT_W-1:0]    s2_slot_reg;
    logic [ADDR_W-1:0]     s2_addr_reg;
    logic                  s2_read_ok_reg;
    logic                  s2_fwd_reg;
    logic [TALLY_W-1:0]    s2_fwd_data_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  cfg_fire;
    logic                  in_fire;
    logic                  s1_fire;
    logic                  s2_fire;
    div_status_t           div_status;
    div_result_t           div_result;
    logic [INTERVAL_W-1:0] cfg_iv_eff;
    logic                  tally_clear_busy;

    logic                  load_ok;
    logic [ENTRY_W-1:0]    load_entry;
    logic [SLOTS_PER_ROW-1:0][ENTRY_W-1:0] thr_row;

    logic [INTERVAL_W-1:0] iv_eff;
    logic                  is_step;
    logic                  is_start;
    logic                  is_read;
    logic [STATE_W-1:0]    pick_state;
    logic                  cnt_ok;
    logic                  do_tally;
    logic [INTERVAL_W:0]   phase_inc;
    logic                  phase_wrap;
    logic [COUNTER_W-1:0]  tslot_ext;
    logic                  read_ok;
    logic [STATE_W-1:0]    state_next;
    logic [ADDR_W-1:0]     s1_addr;
    logic                  tally_re;

    logic [TALLY_W-1:0]    tally_rdata;
    logic [TALLY_W-1:0]    tally_cur;
    logic [TALLY_W-1:0]    tally_wdata;
    logic                  tally_we;
    out_item_t             out_next;

    // handshakes
    always_comb
    begin
        cfg_ready  = !div_status.busy;
        cfg_fire   = cfg_valid && cfg_ready;
        cfg_iv_eff = (cfg_data == '0) ? INTERVAL_W'(1) : cfg_data;
        in_ready   = !s1_valid_reg && !tally_clear_busy && !div_status.busy && !div_status.done;
        in_fire    = in_valid && in_ready;
        s2_fire    = s2_valid_reg && (!out_valid_reg || out_ready);
        s1_fire    = s1_valid_reg && (!s2_valid_reg || s2_fire);
    end

    // threshold load
    always_comb
    begin
        load_ok = (in_data.command == CMD_LOAD)
               && (in_data.entry_slot != ESLOT_W'(SLOTS_PER_ROW))
               && ({1'b0, in_data.entry_state} < STATE_LIMIT)
               && ({1'b0, in_data.entry_next} < STATE_LIMIT);
        load_entry = {in_data.entry_next[STATE_W-1:0], in_data.entry_threshold};
    end

    msts_thr_mem #(
        .NUM_STATES (NUM_STATES)
    ) u_thr_mem (
        .clk   (clk),
        .we    (in_fire && load_ok),
        .waddr (in_data.entry_state[STATE_W-1:0]),
        .wslot (in_data.entry_slot),
        .wdata (load_entry),
        .re    (in_fire),
        .raddr (current_state_reg),
        .rdata (thr_row)
    );

    msts_interval_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_fire),
        .dividend (step_counter_reg),
        .divisor  (cfg_iv_eff),
        .status   (div_status),
        .result   (div_result)
    );

    // stage 1: transition pick, sampling decision, tally read
    always_comb
    begin
        iv_eff   = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;
        is_step  = (s1_item_reg.command == CMD_STEP);
        is_start = (s1_item_reg.command == CMD_START);
        is_read  = (s1_item_reg.command == CMD_READ);

        if (s1_item_reg.random_value < thr_row[0][THR_W-1:0])
        begin
            pick_state = thr_row[0][ENTRY_W-1:THR_W];
        end
        else if (s1_item_reg.random_value < thr_row[1][THR_W-1:0])
        begin
            pick_state = thr_row[1][ENTRY_W-1:THR_W];
        end
        else if (s1_item_reg.random_value < thr_row[2][THR_W-1:0])
        begin
            pick_state = thr_row[2][ENTRY_W-1:THR_W];
        end
        else
        begin
            pick_state = current_state_reg;
        end

        cnt_ok     = (step_counter_reg != COUNTER_MAX);
        do_tally   = is_step && cnt_ok && (phase_reg == '0) && (slot_reg < SLOT_LIMIT);
        phase_inc  = {1'b0, phase_reg} + 1'b1;
        phase_wrap = (phase_inc == {1'b0, iv_eff});

        tslot_ext  = COUNTER_W'(s1_item_reg.tally_slot);
        read_ok    = ({1'b0, s1_item_reg.entry_state} < STATE_LIMIT)
                  && (tslot_ext < SLOT_LIMIT);

        if (is_step)
        begin
            state_next = pick_state;
        end
        else if (is_start)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = current_state_reg;
        end

        if (is_step)
        begin
            s1_addr = {pick_state, slot_reg[SLOT_W-1:0]};
        end
        else
        begin
            s1_addr = {s1_item_reg.entry_state[STATE_W-1:0], tslot_ext[SLOT_W-1:0]};
        end

        tally_re = s1_fire && (do_tally || (is_read && read_ok));
    end

    // stage 2: saturating tally update, result
    always_comb
    begin
        tally_cur   = s2_fwd_reg ? s2_fwd_data_reg : tally_rdata;
        tally_wdata = (tally_cur == TALLY_MAX) ? tally_cur : tally_cur + 1'b1;
        tally_we    = s2_fire && s2_sampled_reg;

        out_next.chain_state_out = OSTATE_W'(s2_state_reg);
        out_next.sampled         = s2_sampled_reg;
        out_next.slot_out        = s2_slot_reg;
        out_next.tally_count     = ((s2_cmd_reg == CMD_READ) && s2_read_ok_reg) ? tally_cur : '0;
    end

    msts_tally_mem #(
        .NUM_STATES (NUM_STATES),
        .TIME_SLOTS (TIME_SLOTS)
    ) u_tally_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .re         (tally_re),
        .raddr      (s1_addr),
        .rdata      (tally_rdata),
        .we         (tally_we),
        .waddr      (s2_addr_reg),
        .wdata      (tally_wdata),
        .clear_busy (tally_clear_busy)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg      <= INTERVAL_RESET;
            current_state_reg <= '0;
            step_counter_reg  <= '0;
            phase_reg         <= '0;
            slot_reg          <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                interval_reg <= cfg_data;
            end

            if (div_status.done)
            begin
                phase_reg <= div_result.phase;
                slot_reg  <= div_result.slot;
            end
            else if (s1_fire && is_start)
            begin
                phase_reg <= '0;
                slot_reg  <= '0;
            end
            else if (s1_fire && is_step && cnt_ok)
            begin
                phase_reg <= phase_wrap ? '0 : phase_inc[INTERVAL_W-1:0];
                slot_reg  <= phase_wrap ? slot_reg + 1'b1 : slot_reg;
            end

            if (s1_fire)
            begin
                current_state_reg <= state_next;
                if (is_start)
                begin
                    step_counter_reg <= '0;
                end
                else if (is_step && cnt_ok)
                begin
                    step_counter_reg <= step_counter_reg + 1'b1;
                end
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_fire)
        begin
            s2_cmd_reg      <= s1_item_reg.command;
            s2_state_reg    <= state_next;
            s2_sampled_reg  <= do_tally;
            s2_slot_reg     <= do_tally ? slot_reg[OSLOT_W-1:0] : '0;
            s2_addr_reg     <= s1_addr;
            s2_read_ok_reg  <= read_ok;
            // same-word write-back in flight
            s2_fwd_reg      <= tally_we && (s2_addr_reg == s1_addr);
            s2_fwd_data_reg <= tally_wdata;
        end
        if (s2_fire)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// File: tb/tb_markov_chain_transition_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markov_chain_transition_sampler_unit
// Self-checking bench for the Markov chain transition sampler. A short table
// of directed requests covers the extremes, bad loads and bad reads. Random
// molecules follow: a start, then a run of steps with random draws, mixed
// with tally reads, table reloads and malformed requests. The sample
// interval is changed between phases. Every result is checked field by field
// against a behavioral model of chain, table and tallies or a typed result.
// ----------------------------------------------------------------------------
module tb_markov_chain_transition_sampler_unit;
    import msts_pkg::*;

    localparam int TIME_SLOTS    = DEF_TIME_SLOTS;
    localparam int NUM_STATES    = DEF_NUM_STATES;
    localparam int TABLE_ROWS    = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_MOLECULE = 1030;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t result;
    } directed_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [INTERVAL_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    // model of the chain
    logic [OSTATE_W-1:0]   chain_now;
    logic [COUNTER_W-1:0]  steps_taken;
    logic [INTERVAL_W-1:0] interval_model;
    logic [THR_W-1:0]      thr_mem   [TABLE_ROWS*SLOTS_PER_ROW];
    logic [ENEXT_W-1:0]    next_mem  [TABLE_ROWS*SLOTS_PER_ROW];
    logic [TALLY_W-1:0]    tally_mem [TABLE_ROWS*TIME_SLOTS];

    out_item_t     pending_results[$];
    directed_row_t directed_rows[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int steps_left    = 0;
    bit force_long    = 1'b0;

    markov_chain_transition_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic out_item_t advance_chain(in_item_t req);
        out_item_t   res;
        int unsigned base;
        int unsigned gap;
        int unsigned n;
        int unsigned addr;
        bit          hit;
        res = '0;
        hit = 1'b0;
        case (req.command)
            CMD_STEP:
            begin
                n    = steps_taken;
                gap  = (interval_model == '0) ? 1 : interval_model;
                base = chain_now * SLOTS_PER_ROW;
                for (int s = 0; s < SLOTS_PER_ROW; s++)
                begin
                    if (!hit && req.random_value < thr_mem[base+s])
                    begin
                        hit       = 1'b1;
                        chain_now = next_mem[base+s];
                    end
                end
                if (steps_taken != COUNTER_MAX)
                begin
                    if (n % gap == 0 && n / gap < TIME_SLOTS)
                    begin
                        addr = chain_now * TIME_SLOTS + n / gap;
                        if (tally_mem[addr] != TALLY_MAX)
                            tally_mem[addr] += 1'b1;
                        res.sampled  = 1'b1;
                        res.slot_out = OSLOT_W'(n / gap);
                    end
                    steps_taken += 1'b1;
                end
            end
            CMD_LOAD:
            begin
                if (req.entry_slot < SLOTS_PER_ROW && req.entry_state < NUM_STATES &&
                    req.entry_next < NUM_STATES)
                begin
                    base           = req.entry_state * SLOTS_PER_ROW + req.entry_slot;
                    thr_mem[base]  = req.entry_threshold;
                    next_mem[base] = req.entry_next;
                end
            end
            CMD_START:
            begin
                chain_now   = '0;
                steps_taken = '0;
            end
            default:
            begin
                if (req.entry_state < NUM_STATES)
                    res.tally_count = tally_mem[req.entry_state * TIME_SLOTS + req.tally_slot];
            end
        endcase
        res.chain_state_out = chain_now;
        return res;
    endfunction

    // one random request; molecules are a start followed by a run of steps
    function automatic in_item_t make_request(output bit noise);
        in_item_t    req;
        logic [63:0] bits;
        int          pick;
        bits  = {$urandom, $urandom};
        req   = bits[$bits(in_item_t)-1:0];
        pick  = $urandom_range(99);
        noise = 1'b0;
        if (pick < 6)
        begin
            noise = 1'b1;
            case ($urandom_range(3))
                0:
                begin
                    req.command    = CMD_LOAD;
                    req.entry_slot = 2'd3;
                end
                1:
                begin
                    req.command     = CMD_LOAD;
                    req.entry_state = ESTATE_W'($urandom_range(15, NUM_STATES));
                end
                2:
                begin
                    req.command    = CMD_LOAD;
                    req.entry_next = ENEXT_W'($urandom_range(15, NUM_STATES));
                end
                default:
                begin
                    req.command     = CMD_READ;
                    req.entry_state = ESTATE_W'($urandom_range(15, NUM_STATES));
                end
            endcase
        end
        else if (pick < 14)
        begin
            req.command     = CMD_READ;
            req.entry_state = ESTATE_W'($urandom_range(NUM_STATES-1));
            if ($urandom_range(9) < 7)
                req.tally_slot = TSLOT_W'($urandom_range(40));
        end
        else if (pick < 18)
        begin
            req.command     = CMD_LOAD;
            req.entry_state = ESTATE_W'($urandom_range(NUM_STATES-1));
            req.entry_slot  = ESLOT_W'($urandom_range(SLOTS_PER_ROW-1));
            req.entry_next  = ENEXT_W'($urandom_range(NUM_STATES-1));
        end
        else if (steps_left == 0)
        begin
            req.command = CMD_START;
            if (force_long)
                steps_left = LONG_MOLECULE;
            else if ($urandom_range(9) < 8)
                steps_left = $urandom_range(40, 1);
            else
                steps_left = $urandom_range(300, 41);
            force_long = 1'b0;
        end
        else
        begin
            req.command = CMD_STEP;
            steps_left--;
            if ($urandom_range(9) == 0)
                req.random_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return req;
    endfunction

    function automatic directed_row_t stim_row(cmd_t cmd, int rnd, int est, int eslot,
                                               int thr, int enext, int tslot, bit typed,
                                               int st_out = 0, int smp = 0,
                                               int slot = 0, int count = 0);
        directed_row_t r;
        r.req.command                = cmd;
        r.req.random_value           = RND_W'(rnd);
        r.req.entry_state            = ESTATE_W'(est);
        r.req.entry_slot             = ESLOT_W'(eslot);
        r.req.entry_threshold        = THR_W'(thr);
        r.req.entry_next             = ENEXT_W'(enext);
        r.req.tally_slot             = TSLOT_W'(tslot);
        r.typed                      = typed;
        r.result.chain_state_out     = OSTATE_W'(st_out);
        r.result.sampled             = smp[0];
        r.result.slot_out            = OSLOT_W'(slot);
        r.result.tally_count         = TALLY_W'(count);
        return r;
    endfunction

    task automatic send_request(in_item_t req, bit typed, out_item_t typed_res);
        out_item_t predicted;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_chain(req);
        pending_results.push_back(typed ? typed_res : predicted);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic write_interval(logic [INTERVAL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid      <= 1'b0;
        interval_model = value;
    endtask

    task automatic run_phase(int send_pct, int recv_pct, logic [INTERVAL_W-1:0] interval,
                             int requests, bit hold);
        in_item_t req;
        bit       noise;
        int       useful;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_interval(interval);
        if (hold)
            hold_asks++;
        useful = 0;
        while (useful < requests)
        begin
            req = make_request(noise);
            send_request(req, 1'b0, '0);
            if (!noise)
                useful++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: %h", out_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.chain_state_out !== want.chain_state_out)
                begin
                    $error("chain_state_out: expected %0d, got %0d",
                           want.chain_state_out, out_data.chain_state_out);
                    error_count++;
                end
                if (out_data.sampled !== want.sampled)
                begin
                    $error("sampled: expected %0d, got %0d", want.sampled, out_data.sampled);
                    error_count++;
                end
                if (out_data.slot_out !== want.slot_out)
                begin
                    $error("slot_out: expected %0d, got %0d", want.slot_out, out_data.slot_out);
                    error_count++;
                end
                if (out_data.tally_count !== want.tally_count)
                begin
                    $error("tally_count: expected %0d, got %0d",
                           want.tally_count, out_data.tally_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t    req;
        logic [63:0] bits;
        chain_now      = '0;
        steps_taken    = '0;
        interval_model = INTERVAL_RESET;
        foreach (thr_mem[i])
        begin
            thr_mem[i]  = '0;
            next_mem[i] = '0;
        end
        foreach (tally_mem[i])
            tally_mem[i] = '0;
        send_idle_pct = 35;
        recv_idle_pct = 58;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_interval(INTERVAL_W'(1));

        // cmd, random, state, slot, threshold, next, tally slot, typed, result
        directed_rows.push_back(stim_row(CMD_READ,  0,      0,  0, 0,      0,  0,    1));
        directed_rows.push_back(stim_row(CMD_READ,  0,      15, 0, 0,      0,  1023, 1));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      0,  0, 0,      12, 0,    0));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      0,  1, 'h8000, 12, 0,    0));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      0,  2, 'hFFFF, 0,  0,    0));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      12, 0, 'h0001, 0,  0,    0));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      12, 1, 'h4000, 12, 0,    0));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      12, 2, 'hFFFF, 12, 0,    0));
        // bad loads leave the table alone
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      0,  3, 'hFFFF, 12, 0,    1));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      13, 0, 'hFFFF, 0,  0,    1));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      0,  0, 'hFFFF, 13, 0,    1));
        directed_rows.push_back(stim_row(CMD_LOAD,  0,      15, 2, 'hFFFF, 15, 1023, 1));
        // top draw is never below a threshold
        directed_rows.push_back(stim_row(CMD_STEP,  'hFFFF, 0,  0, 0,      0,  0,    1,
                                         0, 1, 0, 0));
        directed_rows.push_back(stim_row(CMD_STEP,  0,      0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_STEP,  0,      0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_STEP,  'h7FFF, 0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_STEP,  'hFFFF, 0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_READ,  0,      0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_READ,  0,      12, 0, 0,      0,  4,    0));
        directed_rows.push_back(stim_row(CMD_START, 0,      0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_STEP,  0,      0,  0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_READ,  0,      12, 0, 0,      0,  0,    0));
        directed_rows.push_back(stim_row(CMD_READ,  0,      0,  0, 0,      0,  1023, 0));
        directed_rows.push_back(stim_row(CMD_START, 0,      0,  0, 0,      0,  0,    0));
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

        // fill every row so that no step reads an unwritten entry
        for (int st = 0; st < NUM_STATES; st++)
        begin
            for (int sl = 0; sl < SLOTS_PER_ROW; sl++)
            begin
                bits                = {$urandom, $urandom};
                req                 = bits[$bits(in_item_t)-1:0];
                req.command         = CMD_LOAD;
                req.entry_state     = ESTATE_W'(st);
                req.entry_slot      = ESLOT_W'(sl);
                req.entry_next      = ENEXT_W'($urandom_range(NUM_STATES-1));
                if (sl == SLOTS_PER_ROW-1 && $urandom_range(1))
                    req.entry_threshold = 16'hFFFF;
                send_request(req, 1'b0, '0);
            end
        end

        run_phase(35, 58, INTERVAL_W'(1), 120, 1'b0);
        run_phase(58, 35, INTERVAL_W'(1023), 100, 1'b0);
        steps_left = 0;
        force_long = 1'b1;
        run_phase(0, 0, INTERVAL_W'(0), 800, 1'b0);
        run_phase(0, 0, INTERVAL_W'(5), 120, 1'b1);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/msts_pkg.sv
hw/rtl/msts_interval_div.sv
hw/rtl/msts_thr_mem.sv
hw/rtl/msts_tally_mem.sv
hw/rtl/markov_chain_transition_sampler_unit.sv
tb/tb_markov_chain_transition_sampler_unit.sv
